FILE: rtl/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg
// Shared widths, operation codes and stage records of the vector ALU.
// ----------------------------------------------------------------------------
package v3a_pkg;

   localparam int WORD_W        = 32;
   localparam int FUNC_W        = 4;
   localparam int FRAC_BITS_DEF = 16;
   localparam int PROD_W        = 2 * WORD_W;
   localparam int SUM_W         = PROD_W + 4;
   localparam int ROOT_W        = WORD_W;
   localparam int SQRT_LAT      = ROOT_W + 1;

   localparam logic [FUNC_W-1:0] FN_NEG   = 4'd0;
   localparam logic [FUNC_W-1:0] FN_ADD   = 4'd1;
   localparam logic [FUNC_W-1:0] FN_SUB   = 4'd2;
   localparam logic [FUNC_W-1:0] FN_SCALE = 4'd3;
   localparam logic [FUNC_W-1:0] FN_CROSS = 4'd4;
   localparam logic [FUNC_W-1:0] FN_DOT   = 4'd5;
   localparam logic [FUNC_W-1:0] FN_LEN   = 4'd6;
   localparam logic [FUNC_W-1:0] FN_NORM  = 4'd7;
   localparam logic [FUNC_W-1:0] FN_CMP   = 4'd8;

   typedef logic signed [WORD_W-1:0] word_type;

   // what one lane hands to the merge stage
   typedef struct packed {
      logic signed [PROD_W-1:0] p1;
      logic signed [PROD_W-1:0] p2;
      logic signed [WORD_W:0]   simple;
      logic                     in_tol;
   } lane_type;

   // result record carried down the root and divide pipeline
   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [2:0][WORD_W-1:0]   r;
      logic [WORD_W-1:0]        sc;
      logic                     eq;
      logic [2:0][WORD_W-1:0]   amag;
      logic [2:0]               aneg;
      logic                     dzero;
   } pl_type;

endpackage

FILE: rtl/v3a_lane.sv
// ----------------------------------------------------------------------------
// v3a_lane
// One component lane: two registered multipliers, add/sub/negate, tolerance.
// ----------------------------------------------------------------------------
module v3a_lane (
   input  logic                          clock,
   input  logic                          en,
   input  logic [v3a_pkg::FUNC_W-1:0]    func,
   input  v3a_pkg::word_type             a_i,
   input  v3a_pkg::word_type             a_j,
   input  v3a_pkg::word_type             a_k,
   input  v3a_pkg::word_type             b_i,
   input  v3a_pkg::word_type             b_j,
   input  v3a_pkg::word_type             b_k,
   input  v3a_pkg::word_type             s,
   output v3a_pkg::lane_type             res
);
   import v3a_pkg::*;

   word_type m1a, m1b;
   logic signed [WORD_W:0]   simple_in;
   logic signed [WORD_W+1:0] lo, hi;
   lane_type res_ff;

   always_comb begin
      case (func)
         FN_SCALE: begin m1a = a_i; m1b = s;   end
         FN_CROSS: begin m1a = a_j; m1b = b_k; end
         FN_DOT:   begin m1a = a_i; m1b = b_i; end
         default:  begin m1a = a_i; m1b = a_i; end
      endcase
      case (func)
         FN_NEG:  simple_in = -(WORD_W+1)'(a_i);
         FN_ADD:  simple_in = (WORD_W+1)'(a_i) + (WORD_W+1)'(b_i);
         FN_SUB:  simple_in = (WORD_W+1)'(a_i) - (WORD_W+1)'(b_i);
         default: simple_in = '0;
      endcase
      lo = (WORD_W+2)'(b_i) - (WORD_W+2)'(s);
      hi = (WORD_W+2)'(b_i) + (WORD_W+2)'(s);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff.p1     <= PROD_W'(m1a) * PROD_W'(m1b);
         res_ff.p2     <= PROD_W'(a_k) * PROD_W'(b_j);
         res_ff.simple <= simple_in;
         res_ff.in_tol <= ((WORD_W+2)'(a_i) >= lo) && ((WORD_W+2)'(a_i) <= hi);
      end
   end

   assign res = res_ff;

endmodule

FILE: rtl/v3a_sqrt.sv
// ----------------------------------------------------------------------------
// v3a_sqrt
// Pipelined integer square root, one root bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module v3a_sqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [v3a_pkg::PROD_W-1:0]   n,
   output logic [v3a_pkg::ROOT_W:0]     root
);
   import v3a_pkg::*;

   localparam int RW = ROOT_W + 2;

   logic [RW-1:0]     rem_ff  [0:ROOT_W-1];
   logic [ROOT_W-1:0] rt_ff   [0:ROOT_W-1];
   logic [PROD_W-1:0] n_ff    [0:ROOT_W-1];
   logic [ROOT_W:0]   root_ff;

   genvar k;
   generate
      for (k = 0; k < ROOT_W; k++) begin : g_step
         logic [RW-1:0]     rem_prev;
         logic [ROOT_W-1:0] rt_prev;
         logic [PROD_W-1:0] n_prev;
         logic [RW+1:0]     ext, trial;
         if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign rt_prev  = '0;
            assign n_prev   = n;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign rt_prev  = rt_ff[k-1];
            assign n_prev   = n_ff[k-1];
         end
         assign ext   = {rem_prev, n_prev[PROD_W-1 -: 2]};
         assign trial = {2'b00, rt_prev, 2'b01};
         always_ff @(posedge clock) begin
            if (en) begin
               n_ff[k] <= n_prev << 2;
               if (ext >= trial) begin
                  rem_ff[k] <= RW'(ext - trial);
                  rt_ff[k]  <= {rt_prev[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_ff[k] <= RW'(ext);
                  rt_ff[k]  <= {rt_prev[ROOT_W-2:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   // round up when the remainder exceeds the floor root
   always_ff @(posedge clock) begin
      if (en) begin
         if (rem_ff[ROOT_W-1] > RW'(rt_ff[ROOT_W-1]))
            root_ff <= (ROOT_W+1)'(rt_ff[ROOT_W-1]) + 1'b1;
         else
            root_ff <= (ROOT_W+1)'(rt_ff[ROOT_W-1]);
      end
   end

   assign root = root_ff;

endmodule

FILE: rtl/v3a_div.sv
// ----------------------------------------------------------------------------
// v3a_div
// Pipelined restoring divider for normalize: (mag * 2^F + d/2) / d.
// ----------------------------------------------------------------------------
module v3a_div #(
   parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [v3a_pkg::WORD_W-1:0]   mag,
   input  logic [v3a_pkg::ROOT_W:0]     d,
   output logic [FRAC_BITS+1:0]         q
);
   import v3a_pkg::*;

   localparam int QW = FRAC_BITS + 2;
   localparam int NW = WORD_W + 1 + FRAC_BITS;
   localparam int DW = ROOT_W + 1;
   localparam int RW = DW + 1;

   logic [NW-1:0] num;
   logic [RW-1:0] rem_ff [0:QW-1];
   logic [QW-1:0] low_ff [0:QW-1];
   logic [QW-1:0] q_ff   [0:QW-1];
   logic [DW-1:0] d_ff   [0:QW-1];

   assign num = (NW'(mag) << FRAC_BITS) + NW'(d >> 1);

   genvar k;
   generate
      for (k = 0; k < QW; k++) begin : g_step
         logic [RW-1:0] rem_prev, ext;
         logic [QW-1:0] low_prev, q_prev;
         logic [DW-1:0] d_prev;
         if (k == 0) begin : g_first
            // the top part of the dividend is already below the divisor
            assign rem_prev = RW'(num[NW-1:QW]);
            assign low_prev = num[QW-1:0];
            assign q_prev   = '0;
            assign d_prev   = d;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign low_prev = low_ff[k-1];
            assign q_prev   = q_ff[k-1];
            assign d_prev   = d_ff[k-1];
         end
         assign ext = {rem_prev[RW-2:0], low_prev[QW-1]};
         always_ff @(posedge clock) begin
            if (en) begin
               d_ff[k]   <= d_prev;
               low_ff[k] <= low_prev << 1;
               if (ext >= RW'(d_prev)) begin
                  rem_ff[k] <= ext - RW'(d_prev);
                  q_ff[k]   <= {q_prev[QW-2:0], 1'b1};
               end else begin
                  rem_ff[k] <= ext;
                  q_ff[k]   <= {q_prev[QW-2:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   assign q = q_ff[QW-1];

endmodule

FILE: rtl/vector3_alu.sv
// ----------------------------------------------------------------------------
// vector3_alu
// Three-component vector ALU in signed fixed point with three parallel lanes.
// ----------------------------------------------------------------------------
// Takes one item per cycle while req_stall is low and returns one result per
// item, in order; at the default FRAC_BITS the format is Q16.16. The depth is
// set by the 33-stage square root pipeline (32 root bits and a rounding stage)
// followed by the FRAC_BITS+2 stage normalize dividers; every operation
// travels the same path so results never reorder. A stall while a result
// beat is waiting holds the whole pipeline and shows up on req_stall in the
// same cycle.
module vector3_alu #(
   parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [v3a_pkg::FUNC_W-1:0]   req_func,
   input  v3a_pkg::word_type            req_ax,
   input  v3a_pkg::word_type            req_ay,
   input  v3a_pkg::word_type            req_az,
   input  v3a_pkg::word_type            req_bx,
   input  v3a_pkg::word_type            req_by,
   input  v3a_pkg::word_type            req_bz,
   input  v3a_pkg::word_type            req_scalar_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output v3a_pkg::word_type            rsp_rx,
   output v3a_pkg::word_type            rsp_ry,
   output v3a_pkg::word_type            rsp_rz,
   output v3a_pkg::word_type            rsp_scalar_out,
   output logic                         rsp_equal_flag
);
   import v3a_pkg::*;

   localparam int QW     = FRAC_BITS + 2;
   localparam int PIPE_D = SQRT_LAT + QW;
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] WMAX = SUM_W'(32'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] WMIN = -(SUM_W'(32'sh7FFF_FFFF)) - 1;

   function automatic logic [WORD_W-1:0] sat_w(input logic signed [SUM_W-1:0] v);
      if (v > WMAX)      return WORD_W'(WMAX);
      else if (v < WMIN) return WORD_W'(WMIN);
      else               return WORD_W'(v);
   endfunction

   function automatic logic [WORD_W-1:0] rnd_sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = (v + HALF) >>> FRAC_BITS;
      return sat_w(t);
   endfunction

   logic adv;

   // input stage
   logic                   v1_ff;
   logic [FUNC_W-1:0]      func1_ff;
   logic [2:0][WORD_W-1:0] a1_ff, b1_ff;
   logic [WORD_W-1:0]      s1_ff;

   // lane stage
   lane_type               lane_res [0:2];
   logic                   v2_ff;
   logic [FUNC_W-1:0]      func2_ff;
   logic [2:0][WORD_W-1:0] amag2_ff;
   logic [2:0]             aneg2_ff;

   // merge and long pipeline
   pl_type                 pl_in;
   logic [PROD_W-1:0]      sq_in;
   pl_type                 pl_ff [0:PIPE_D];
   logic                   v_ff  [0:PIPE_D];
   logic [ROOT_W:0]        root_d;
   pl_type                 pl_len;
   logic [FRAC_BITS+1:0]   q [0:2];

   pl_type                 out_in, out_ff;
   logic                   rsp_valid_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         func1_ff <= req_func;
         a1_ff    <= {req_az, req_ay, req_ax};
         b1_ff    <= {req_bz, req_by, req_bx};
         s1_ff    <= req_scalar_in;
         func2_ff <= func1_ff;
      end
   end

   genvar i;
   generate
      for (i = 0; i < 3; i++) begin : g_lane
         v3a_lane u_lane (
            .clock (clock),
            .en    (adv),
            .func  (func1_ff),
            .a_i   (a1_ff[i]),
            .a_j   (a1_ff[(i+1)%3]),
            .a_k   (a1_ff[(i+2)%3]),
            .b_i   (b1_ff[i]),
            .b_j   (b1_ff[(i+1)%3]),
            .b_k   (b1_ff[(i+2)%3]),
            .s     (s1_ff),
            .res   (lane_res[i])
         );
         always_ff @(posedge clock) begin
            if (adv) begin
               aneg2_ff[i] <= a1_ff[i][WORD_W-1];
               amag2_ff[i] <= a1_ff[i][WORD_W-1] ? -a1_ff[i] : a1_ff[i];
            end
         end
      end
   endgenerate

   // merge: combine what the lanes produced
   always_comb begin
      pl_in      = '0;
      pl_in.func = func2_ff;
      pl_in.amag = amag2_ff;
      pl_in.aneg = aneg2_ff;
      for (int n = 0; n < 3; n++) begin
         case (func2_ff)
            FN_NEG, FN_ADD, FN_SUB: pl_in.r[n] = sat_w(SUM_W'(lane_res[n].simple));
            FN_SCALE: pl_in.r[n] = rnd_sat(SUM_W'(lane_res[n].p1));
            FN_CROSS: pl_in.r[n] = rnd_sat(SUM_W'(lane_res[n].p1) - SUM_W'(lane_res[n].p2));
            default:  pl_in.r[n] = '0;
         endcase
      end
      case (func2_ff)
         FN_DOT:  pl_in.sc = rnd_sat(SUM_W'(lane_res[0].p1) + SUM_W'(lane_res[1].p1)
                                     + SUM_W'(lane_res[2].p1));
         default: pl_in.sc = '0;
      endcase
      case (func2_ff)
         FN_CMP:  pl_in.eq = lane_res[0].in_tol && lane_res[1].in_tol
                             && lane_res[2].in_tol;
         default: pl_in.eq = 1'b0;
      endcase
      // squares are never negative, so the low word sum is exact
      sq_in = PROD_W'(lane_res[0].p1) + PROD_W'(lane_res[1].p1) + PROD_W'(lane_res[2].p1);
   end

   logic [PROD_W-1:0] sq_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff[0] <= pl_in;
         sq_ff    <= sq_in;
      end
   end

   v3a_sqrt u_sqrt (
      .clock (clock),
      .en    (adv),
      .n     (sq_ff),
      .root  (root_d)
   );

   // length result and zero-vector mark join the record when the root is out
   always_comb begin
      pl_len       = pl_ff[SQRT_LAT];
      pl_len.dzero = (root_d == '0);
      if (pl_ff[SQRT_LAT].func == FN_LEN) begin
         if (root_d > (ROOT_W+1)'(32'h7FFF_FFFF))
            pl_len.sc = 32'h7FFF_FFFF;
         else
            pl_len.sc = root_d[WORD_W-1:0];
      end
   end

   genvar k;
   generate
      for (k = 1; k <= PIPE_D; k++) begin : g_dly
         always_ff @(posedge clock) begin
            if (adv) begin
               if (k == SQRT_LAT + 1)
                  pl_ff[k] <= pl_len;
               else
                  pl_ff[k] <= pl_ff[k-1];
            end
         end
      end
      for (i = 0; i < 3; i++) begin : g_div
         v3a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .clock (clock),
            .en    (adv),
            .mag   (pl_ff[SQRT_LAT].amag[i]),
            .d     (root_d),
            .q     (q[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n <= PIPE_D; n++) v_ff[n] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= v2_ff;
         for (int n = 1; n <= PIPE_D; n++) v_ff[n] <= v_ff[n-1];
         rsp_valid_ff <= v_ff[PIPE_D];
      end
   end

   always_comb begin
      out_in = pl_ff[PIPE_D];
      if (pl_ff[PIPE_D].func == FN_NORM) begin
         for (int n = 0; n < 3; n++) begin
            if (pl_ff[PIPE_D].dzero)
               out_in.r[n] = '0;
            else if (pl_ff[PIPE_D].aneg[n])
               out_in.r[n] = -(WORD_W'(q[n]));
            else
               out_in.r[n] = WORD_W'(q[n]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rx         = out_ff.r[0];
   assign rsp_ry         = out_ff.r[1];
   assign rsp_rz         = out_ff.r[2];
   assign rsp_scalar_out = out_ff.sc;
   assign rsp_equal_flag = out_ff.eq;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the fixed-point 3-vector ALU against a predictor.
// ----------------------------------------------------------------------------
// Every accepted request is run through a local model of the operations and
// the expected result is queued; results are checked in order, field by field.
// Both sides insert random idle cycles, the receiver also holds off for a long
// stretch once, and the sender drains the pipeline once before going on.
module tb_top;
   import v3a_pkg::*;

   typedef struct {
      logic [31:0] rx, ry, rz, sc;
      logic        eq;
   } vec_result_type;

   class alu_scoreboard;
      vec_result_type pending[$];
      int             mismatches;

      function automatic longint rnd_q(longint v);
         longint fl;
         fl = v >>> 16;
         return fl + ((v - (fl <<< 16)) >= 32768 ? 1 : 0);
      endfunction

      function automatic logic [31:0] sat(longint v);
         if (v > 64'sd2147483647) return 32'h7fffffff;
         if (v < -64'sd2147483648) return 32'h80000000;
         return v[31:0];
      endfunction

      function automatic longint usqrt_round(longint unsigned n);
         longint unsigned r, bit_v;
         r = 0;
         bit_v = 64'd1 << 62;
         while (bit_v > n) bit_v >>= 2;
         while (bit_v != 0) begin
            if (n >= r + bit_v) begin
               n = n - (r + bit_v);
               r = (r >> 1) + bit_v;
            end else begin
               r >>= 1;
            end
            bit_v >>= 2;
         end
         if (n > r) r++;
         return r;
      endfunction

      // dot product with a 68-bit exact accumulator
      function automatic longint rnd_q_exact(longint a[3], longint b[3]);
         logic signed [67:0] acc, fl;
         acc = 0;
         for (int i = 0; i < 3; i++) acc += 68'(signed'(a[i] * b[i]));
         fl = acc >>> 16;
         if ((acc - (fl <<< 16)) >= 32768) fl += 1;
         if (fl > 68'sd2147483647) return 64'sd2147483648;
         if (fl < -68'sd2147483648) return -64'sd2147483649;
         return longint'(fl);
      endfunction

      function automatic vec_result_type compute_result(logic [3:0] fn, longint a[3],
            longint b[3], longint s);
         vec_result_type res;
         longint r[3], sc, d, q;
         longint unsigned sq, m;
         int j, k;
         r = '{0, 0, 0};
         sc = 0;
         res.eq = 0;
         case (fn)
            FN_NEG: for (int i = 0; i < 3; i++) r[i] = -a[i];
            FN_ADD: for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
            FN_SUB: for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
            FN_SCALE: for (int i = 0; i < 3; i++) r[i] = rnd_q(a[i] * s);
            FN_CROSS: for (int i = 0; i < 3; i++) begin
               j = (i + 1) % 3;
               k = (i + 2) % 3;
               // each product fits in 63 bits so the difference fits in 64
               r[i] = rnd_q(a[j] * b[k] - a[k] * b[j]);
            end
            FN_DOT: sc = rnd_q_exact(a, b);
            FN_LEN, FN_NORM: begin
               sq = 0;
               for (int i = 0; i < 3; i++) begin
                  m = a[i] < 0 ? -a[i] : a[i];
                  sq += m * m;
               end
               d = usqrt_round(sq);
               if (fn == FN_LEN) sc = d;
               else if (d != 0)
                  for (int i = 0; i < 3; i++) begin
                     m = a[i] < 0 ? -a[i] : a[i];
                     q = ((m << 16) + (d >> 1)) / d;
                     r[i] = a[i] < 0 ? -q : q;
                  end
            end
            FN_CMP: begin
               res.eq = 1;
               for (int i = 0; i < 3; i++)
                  if (!(a[i] >= b[i] - s && a[i] <= b[i] + s)) res.eq = 0;
            end
            default: ;
         endcase
         res.rx = sat(r[0]);
         res.ry = sat(r[1]);
         res.rz = sat(r[2]);
         res.sc = sat(sc);
         return res;
      endfunction

      function void note_request(logic [3:0] fn, logic [31:0] ax, ay, az, bx, by, bz,
            sin);
         longint a[3], b[3];
         a = '{longint'(signed'(ax)), longint'(signed'(ay)), longint'(signed'(az))};
         b = '{longint'(signed'(bx)), longint'(signed'(by)), longint'(signed'(bz))};
         pending.push_back(compute_result(fn, a, b, longint'(signed'(sin))));
      endfunction

      function void check_result(logic [31:0] rx, ry, rz, sc, logic eq);
         vec_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h %h %h %h %b",
               rx, ry, rz, sc, eq);
            return;
         end
         e = pending.pop_front();
         if (e.rx !== rx || e.ry !== ry || e.rz !== rz || e.sc !== sc || e.eq !== eq)
         begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %h %h %h %h %b, got %h %h %h %h %b",
                  e.rx, e.ry, e.rz, e.sc, e.eq, rx, ry, rz, sc, eq);
         end
      endfunction
   endclass

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, rsp_stall = 0;
   logic        req_stall, rsp_valid, rsp_equal_flag;
   logic [3:0]  req_func = '0;
   word_type    req_ax = '0, req_ay = '0, req_az = '0, req_bx = '0, req_by = '0;
   word_type    req_bz = '0, req_scalar_in = '0;
   word_type    rsp_rx, rsp_ry, rsp_rz, rsp_scalar_out;

   alu_scoreboard sb = new();
   bit  stim_done = 0, hold_now = 0, hold_req = 0;
   int  idle_cycles = 0;

   vector3_alu uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // request beat accepted / result beat accepted
   always @(posedge clock) if (!reset) begin
      if (req_valid && !req_stall)
         sb.note_request(req_func, req_ax, req_ay, req_az, req_bx, req_by, req_bz,
            req_scalar_in);
      if (rsp_valid && !rsp_stall)
         sb.check_result(rsp_rx, rsp_ry, rsp_rz, rsp_scalar_out, rsp_equal_flag);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("vector3_alu test failed");
         $finish;
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return 32'h0;
         3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
         4: return $urandom_range(0, 1) ? $urandom & 32'h000fffff : -($urandom & 32'h000fffff);
         default: return $urandom;
      endcase
   endfunction

   task automatic send(logic [3:0] fn, logic [31:0] ax, ay, az, bx, by, bz, s,
         bit gaps);
      int w;
      w = gaps ? $urandom_range(0, 5) : 0;
      if (w > 0) begin
         req_valid <= 0;
         repeat (w) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= fn;
      {req_ax, req_ay, req_az} <= {ax, ay, az};
      {req_bx, req_by, req_bz} <= {bx, by, bz};
      req_scalar_in <= s;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random(bit gaps);
      logic [31:0] ax, ay, az, s;
      logic [3:0]  fn;
      fn = $urandom_range(0, 19) == 0 ? $urandom_range(9, 15) : $urandom_range(0, 8);
      ax = pick_word(); ay = pick_word(); az = pick_word();
      s = pick_word();
      if (fn == FN_CMP && $urandom_range(0, 1))
         // near-equal vectors so the tolerance actually matters
         send(fn, ax, ay, az, ax + $urandom_range(0, 40) - 20, ay + $urandom_range(0, 8) - 4,
            az, $urandom_range(0, 30), gaps);
      else
         send(fn, ax, ay, az, pick_word(), pick_word(), pick_word(), s, gaps);
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      int w;
      @(negedge reset);
      forever begin
         @(posedge clock);
         w = (stim_done || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 5);
         if (hold_req && !hold_now) begin
            hold_now = 1;
            rsp_stall <= 1;
            repeat (200) @(posedge clock);
            rsp_stall <= 0;
            hold_req = 0;
         end else if (w > 0) begin
            rsp_stall <= 1;
            repeat (w) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   initial begin
      int n;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed part
      send(FN_NEG, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0, 0);
      send(FN_ADD, 32'h7fffffff, 32'h80000000, 5, 1, 32'hffffffff, 7, 0, 0);
      send(FN_SUB, 32'h80000000, 32'h7fffffff, 3, 1, 32'hffffffff, 3, 0, 0);
      send(FN_SCALE, 32'h00018000, 32'hffff8000, 32'h7fffffff, 0, 0, 0, 32'h00008000, 0);
      send(FN_SCALE, 32'h80000000, 1, 32'hffffffff, 0, 0, 0, 32'h80000000, 0);
      send(FN_CROSS, 32'h00010000, 0, 0, 0, 32'h00010000, 0, 0, 0);
      send(FN_CROSS, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
         32'h7fffffff, 32'h80000000, 0, 0);
      send(FN_DOT, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
         32'h80000000, 32'h80000000, 0, 0);
      send(FN_DOT, 32'h00020000, 3, 32'hffffffff, 32'h00008000, 32'h00008000, 1, 0, 0);
      send(FN_LEN, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0, 0);
      send(FN_LEN, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0);
      send(FN_NORM, 0, 0, 0, 0, 0, 0, 0, 0);
      send(FN_NORM, 32'h80000000, 1, 32'hffffffff, 0, 0, 0, 0, 0);
      send(FN_NORM, 1, 0, 0, 0, 0, 0, 0, 0);
      send(FN_CMP, 5, 6, 7, 5, 6, 7, 0, 0);
      send(FN_CMP, 5, 6, 7, 5, 6, 8, 0, 0);
      send(FN_CMP, 5, 6, 7, 6, 6, 7, 1, 0);
      send(FN_CMP, 5, 6, 7, 5, 6, 7, 32'hffffffff, 0);
      send(FN_CMP, 32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 32'h7fffffff, 0);
      send(4'd9, 1, 2, 3, 4, 5, 6, 7, 0);
      send(4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
         32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
      // long receiver hold-off while requests keep coming
      hold_req = 1;
      for (n = 0; n < 150; n++) send_random(0);
      req_valid <= 0;
      // drain completely, then continue with gaps
      while (sb.pending.size() != 0) @(posedge clock);
      for (n = 0; n < 1150; n++) send_random(n % 200 < 150);
      req_valid <= 0;
      stim_done = 1;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.mismatches == 0) $display("vector3_alu test passed");
      else $display("vector3_alu test failed");
      $finish;
   end
endmodule
